// ===== src/bvl_pkg.sv =====
// bvl_pkg: shared types and constants for the braking velocity limit
// no dependencies
package bvl_pkg;

  localparam int ACCEL_W = 12;
  localparam int DELAY_W = 11;
  localparam int POS_W   = 16;
  localparam int VEL_W   = 13;
  localparam int DIST_W  = 12;
  localparam int AT_W    = 22;
  localparam int AD_W    = 23;
  localparam int X_W     = 26;
  localparam int K_W     = 48;
  localparam int RAD_W   = 52;
  localparam int ROOT_W  = 26;
  localparam int DIFF_W  = 24;
  localparam int RECIP_W = 25;
  localparam int PROD_W  = DIFF_W + RECIP_W;

  localparam logic [ACCEL_W-1:0] ACCEL_MAX   = 12'd3000;
  localparam logic [DELAY_W-1:0] DELAY_MAX   = 11'd1000;
  localparam logic [DIST_W-1:0]  DIST_MAX    = 12'd2400;
  localparam logic [VEL_W-1:0]   VEL_MAX     = 13'd8000;
  localparam logic [24:0]        DIST_SCALE  = 25'd32000000;
  // ceil(2^34 / 1000), exact floor division for differences below 2^24
  localparam logic [RECIP_W-1:0] RECIP_1000  = 25'd17179870;
  localparam int                 RECIP_SHIFT = 34;

  localparam logic [ACCEL_W-1:0] ACCEL_RESET = 12'd1000;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 11'd0;

  // register index, taken from paddr[2]
  localparam logic REG_ACCEL = 1'b0;
  localparam logic REG_DELAY = 1'b1;

  // one slot of the square root pipeline
  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [X_W-1:0]    x;
  } sqrt_bus_t;

endpackage

// ===== src/braking_velocity_limit.sv =====
// braking_velocity_limit: v = sqrt((a*t)^2 + 2*a*d) - a*t per position error
// pipeline: 3 product/radicand stages, 26 square root stages one bit each,
//   a divide stage and the output register
// throughput: one transaction per cycle; the whole pipeline holds while the
//   output register waits on m_tready
// reset: synchronous active-high rst clears all valid bits, accel_limit to 1000
//   and reaction_delay to 0; no clearing pass
module braking_velocity_limit (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] position_error
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [12:0] speed_limit, [15:13] zero
  output logic        m_tuser,   // [0] ok
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ROOT_W = bvl_pkg::ROOT_W;

  logic [bvl_pkg::ACCEL_W-1:0] accel_limit;
  logic [bvl_pkg::DELAY_W-1:0] reaction_delay;
  logic                        cfg_wr;
  logic                        ce;
  logic [bvl_pkg::VEL_W-1:0]   vel;

  // slot k feeds the stage for root bit ROOT_W-1-k
  bvl_pkg::sqrt_bus_t          chain [ROOT_W+1];

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit    <= bvl_pkg::ACCEL_RESET;
      reaction_delay <= bvl_pkg::DELAY_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        bvl_pkg::REG_ACCEL: accel_limit    <= pwdata[bvl_pkg::ACCEL_W-1:0];
        bvl_pkg::REG_DELAY: reaction_delay <= pwdata[bvl_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bvl_pkg::REG_ACCEL: prdata = 32'(accel_limit);
      bvl_pkg::REG_DELAY: prdata = 32'(reaction_delay);
      default:            prdata = '0;
    endcase
  end

  // the pipeline moves whenever the output register is free or being drained
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  bvl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .ce             (ce),
    .in_vld         (s_tvalid),
    .position_error (s_tdata),
    .accel_limit    (accel_limit),
    .reaction_delay (reaction_delay),
    .out            (chain[0])
  );

  // one root bit per stage, most significant first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    bvl_sqrt_stage #(
      .BIT (ROOT_W - 1 - k)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .ce  (ce),
      .in  (chain[k]),
      .out (chain[k+1])
    );
  end

  bvl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .in          (chain[ROOT_W]),
    .out_vld     (m_tvalid),
    .speed_limit (vel),
    .ok          (m_tuser)
  );

  assign m_tdata = {3'b000, vel};

`ifndef ASSERT_OFF
  // a rejected configuration always carries a zero limit
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (vel == '0))
    else $error("rejected transaction with nonzero limit");

  // the limit never exceeds 500 mm/s
  a_vel_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (vel <= bvl_pkg::VEL_MAX))
    else $error("velocity limit above clamp");

  // a stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  // an acceleration write lands in the register on the next cycle
  a_accel_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && (paddr[2] == bvl_pkg::REG_ACCEL))
      |=> (accel_limit == $past(pwdata[bvl_pkg::ACCEL_W-1:0])))
    else $error("accel_limit write lost");
`endif

endmodule

// ===== src/bvl_front.sv =====
// bvl_front: distance clamp, products and radicand, three register stages
// depends on bvl_pkg
module bvl_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_vld,
  input  logic signed [bvl_pkg::POS_W-1:0]   position_error,
  input  logic [bvl_pkg::ACCEL_W-1:0]  accel_limit,
  input  logic [bvl_pkg::DELAY_W-1:0]  reaction_delay,
  output bvl_pkg::sqrt_bus_t           out
);

  logic                        cfg_ok;
  logic [bvl_pkg::ACCEL_W-1:0] a_eff;
  logic [16:0]                 mag;
  logic [bvl_pkg::DIST_W-1:0]  dist_clamp;

  // stage 1
  logic                        s1_vld;
  logic                        s1_ok;
  logic [bvl_pkg::AT_W-1:0]    s1_at;
  logic [bvl_pkg::AD_W-1:0]    s1_ad;
  // stage 2
  logic                        s2_vld;
  logic                        s2_ok;
  logic [bvl_pkg::X_W-1:0]     s2_x;
  logic [bvl_pkg::RAD_W-1:0]   s2_xx;
  logic [bvl_pkg::K_W-1:0]     s2_k;
  // stage 3
  logic                        s3_vld;
  logic                        s3_ok;
  logic [bvl_pkg::X_W-1:0]     s3_x;
  logic [bvl_pkg::RAD_W-1:0]   s3_r;

  // bad settings zero the acceleration so the whole datapath yields zero
  assign cfg_ok = (accel_limit != '0) && (accel_limit <= bvl_pkg::ACCEL_MAX)
                  && (reaction_delay <= bvl_pkg::DELAY_MAX);
  assign a_eff  = cfg_ok ? accel_limit : '0;
  assign mag    = position_error[bvl_pkg::POS_W-1]
                  ? (17'h10000 - {1'b0, position_error})
                  : {1'b0, position_error};
  assign dist_clamp = (mag > 17'(bvl_pkg::DIST_MAX)) ? bvl_pkg::DIST_MAX : mag[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (ce) begin
      s1_vld <= in_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_ok <= cfg_ok;
      s1_at <= {10'b0, a_eff} * {12'b0, reaction_delay[9:0]};
      s1_ad <= {11'b0, a_eff} * {11'b0, dist_clamp};
      s2_ok <= s1_ok;
      s2_x  <= {s1_at, 4'b0000};
      s2_xx <= {26'b0, s1_at, 4'b0000} * {26'b0, s1_at, 4'b0000};
      s2_k  <= {25'b0, s1_ad} * {23'b0, bvl_pkg::DIST_SCALE};
      s3_ok <= s2_ok;
      s3_x  <= s2_x;
      s3_r  <= s2_xx + bvl_pkg::RAD_W'(s2_k);
    end
  end

  assign out.vld  = s3_vld;
  assign out.ok   = s3_ok;
  assign out.rem  = s3_r;
  assign out.root = '0;
  assign out.x    = s3_x;

endmodule

// ===== src/bvl_sqrt_stage.sv =====
// bvl_sqrt_stage: one root bit of the truncating square root, registered
// depends on bvl_pkg
module bvl_sqrt_stage #(
  parameter int BIT = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  bvl_pkg::sqrt_bus_t in,
  output bvl_pkg::sqrt_bus_t out
);

  logic [bvl_pkg::RAD_W:0] trial;
  logic                    take;

  // (P + 2^BIT)^2 - P^2 = P*2^(BIT+1) + 2^(2*BIT); P has no bits at or below BIT
  assign trial = ((bvl_pkg::RAD_W+1)'(in.root) << (BIT + 1))
               | ((bvl_pkg::RAD_W+1)'(1) << (2 * BIT));
  assign take  = {1'b0, in.rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.vld <= 1'b0;
    end else if (ce) begin
      out.vld <= in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out.ok   <= in.ok;
      out.x    <= in.x;
      out.rem  <= take ? bvl_pkg::RAD_W'({1'b0, in.rem} - trial) : in.rem;
      out.root <= take ? (in.root | (bvl_pkg::ROOT_W'(1) << BIT)) : in.root;
    end
  end

endmodule

// ===== src/bvl_back.sv =====
// bvl_back: root minus reaction term, divide by 1000, clamp, output register
// depends on bvl_pkg
module bvl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  bvl_pkg::sqrt_bus_t          in,
  output logic                        out_vld,
  output logic [bvl_pkg::VEL_W-1:0]   speed_limit,
  output logic                        ok
);

  logic [bvl_pkg::ROOT_W-1:0] diff;
  logic                       d_vld;
  logic                       d_ok;
  logic [bvl_pkg::PROD_W-1:0] d_prod;
  logic [14:0]                quot;

  // root never falls below x, and the difference stays under 2^24
  assign diff = in.root - in.x;
  assign quot = d_prod[bvl_pkg::PROD_W-1:bvl_pkg::RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (ce) begin
      d_vld   <= in.vld;
      out_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_ok        <= in.ok;
      d_prod      <= diff[bvl_pkg::DIFF_W-1:0] * bvl_pkg::RECIP_1000;
      ok          <= d_ok;
      speed_limit <= (quot > 15'(bvl_pkg::VEL_MAX)) ? bvl_pkg::VEL_MAX
                                                    : quot[12:0];
    end
  end

endmodule
